### sv/rlmc_pkg.sv
package rlmc_pkg;

	localparam int TICK_W     = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 32;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 40;

	localparam logic [7:0]        LEVEL_MAX = 8'hFF;
	localparam logic [7:0]        LEVEL_MIN = 8'h00;
	localparam logic [TICK_W-1:0] TICK_SAT  = '1;

	localparam logic [15:0] BLINK_RST = 16'd60;
	localparam logic [15:0] PULSE_RST = 16'd6;
	localparam logic [7:0]  FADE_RST  = 8'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_BLINK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FADE  = 2'd2;

	typedef enum logic [1:0] {
		MODE_ON    = 2'd0,
		MODE_OFF   = 2'd1,
		MODE_BLINK = 2'd2,
		MODE_PULSE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_MODE   = 2'd1,
		REQ_COLOUR = 2'd2
	} req_t;

	typedef struct packed {
		logic [15:0] blink_period_ms;
		logic [15:0] pulse_period_ms;
		logic [7:0]  fade_step;
	} cfg_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] new_mode;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] level;
		mode_t      mode;
	} led_t;

endpackage

### sv/rlmc_core.sv
module rlmc_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  rlmc_pkg::item_t item,
	input  rlmc_pkg::cfg_t  cfg,
	output rlmc_pkg::led_t  led
);
	import rlmc_pkg::*;

	mode_t             mode_q, mode_d;
	logic [7:0]        level_q, level_d;
	logic              down_q, down_d;
	logic [TICK_W-1:0] ticks_q, ticks_d, ticks_inc;
	logic [7:0]        red_q, green_q, blue_q;
	logic [7:0]        red_d, green_d, blue_d;
	logic [8:0]        up_sum;
	logic [7:0]        step_lvl;

	assign ticks_inc = (ticks_q == TICK_SAT) ? ticks_q : ticks_q + {{(TICK_W-1){1'b0}}, 1'b1};
	assign up_sum    = {1'b0, level_q} + {1'b0, cfg.fade_step};

	// clamp the pulse step at either end
	always_comb begin
		if (down_q) begin
			step_lvl = (level_q < cfg.fade_step) ? LEVEL_MIN : level_q - cfg.fade_step;
		end else begin
			step_lvl = up_sum[8] ? LEVEL_MAX : up_sum[7:0];
		end
	end

	always_comb begin
		mode_d  = mode_q;
		level_d = level_q;
		down_d  = down_q;
		ticks_d = ticks_q;
		red_d   = red_q;
		green_d = green_q;
		blue_d  = blue_q;
		case (req_t'(item.req_type))
			REQ_TICK: begin
				ticks_d = ticks_inc;
				case (mode_q)
					MODE_OFF: level_d = LEVEL_MIN;
					MODE_BLINK: begin
						if (ticks_inc > {1'b0, cfg.blink_period_ms}) begin
							level_d = (level_q == LEVEL_MIN) ? LEVEL_MAX : LEVEL_MIN;
							ticks_d = '0;
						end
					end
					MODE_PULSE: begin
						if (ticks_inc > {1'b0, cfg.pulse_period_ms}) begin
							level_d = step_lvl;
							if (step_lvl == LEVEL_MIN || step_lvl == LEVEL_MAX) begin
								down_d = ~down_q;
							end
							ticks_d = '0;
						end
					end
					default: level_d = LEVEL_MAX;
				endcase
			end
			REQ_MODE: begin
				if (mode_t'(item.new_mode) != mode_q) begin
					mode_d = mode_t'(item.new_mode);
					case (mode_t'(item.new_mode))
						MODE_ON:  level_d = LEVEL_MAX;
						MODE_OFF: level_d = LEVEL_MIN;
						MODE_PULSE: begin
							level_d = LEVEL_MIN;
							down_d  = 1'b0;
						end
						default: ;
					endcase
				end
			end
			REQ_COLOUR: begin
				red_d   = item.red_in;
				green_d = item.green_in;
				blue_d  = item.blue_in;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ON;
			level_q <= LEVEL_MAX;
			down_q  <= 1'b0;
			ticks_q <= TICK_SAT;
			red_q   <= 8'd0;
			green_q <= 8'd255;
			blue_q  <= 8'd0;
		end else if (en) begin
			mode_q  <= mode_d;
			level_q <= level_d;
			down_q  <= down_d;
			ticks_q <= ticks_d;
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
		end
	end

	assign led = '{red: red_q, green: green_q, blue: blue_q, level: level_q, mode: mode_q};

endmodule

### sv/rgb_led_mode_controller.sv
// The result of an accepted input beat reaches m_tdata through the stages listed below.
// Throughput: one beat per cycle; the pipeline moves as a whole and stalls only
// while a result waits on m_tready.
// Stages: input register, LED state update, colour-by-level products, divide by 255.
// Reset (arst_n low): mode on, level 255, colour green, tick counter saturated,
// periods 60 and 6 ticks, fade step 3; no beats in flight.
module rgb_led_mode_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [1:0] new_mode, [9:2] red_in, [17:10] green_in, [25:18] blue_in, rest zero
	input  logic [rlmc_pkg::S_TDATA_W-1:0]  s_tdata,
	// [1:0] req_type
	input  logic [rlmc_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] red_out, [15:8] green_out, [23:16] blue_out, [31:24] level_out,
	// [33:32] mode_out, rest zero
	output logic [rlmc_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                            cfg_we,
	input  logic [rlmc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [rlmc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rlmc_pkg::*;

	cfg_t        cfg_q;
	logic        adv;
	logic        valid_s1, valid_s2, valid_s3, valid_q;
	item_t       item_s1;
	led_t        led;
	logic [15:0] red_s3, green_s3, blue_s3;
	logic [7:0]  level_s3;
	mode_t       mode_s3;
	logic [7:0]  red_o, green_o, blue_o;

	// floor(p / 255) for p below 65280
	function automatic logic [7:0] div255(input logic [15:0] p);
		logic [16:0] t;
		t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	assign adv      = ~valid_q | m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{blink_period_ms: BLINK_RST, pulse_period_ms: PULSE_RST,
			           fade_step: FADE_RST};
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_BLINK: cfg_q.blink_period_ms <= cfg_data;
				CFG_PULSE: cfg_q.pulse_period_ms <= cfg_data;
				CFG_FADE:  cfg_q.fade_step       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_q  <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= '{req_type: s_tuser, new_mode: s_tdata[1:0], red_in: s_tdata[9:2],
			             green_in: s_tdata[17:10], blue_in: s_tdata[25:18]};
		end
	end

	rlmc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv & valid_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.led    (led)
	);

	// the state registers hold the post-item snapshot as stage two
	always_ff @(posedge clk) begin
		if (adv) begin
			red_s3   <= led.red * led.level;
			green_s3 <= led.green * led.level;
			blue_s3  <= led.blue * led.level;
			level_s3 <= led.level;
			mode_s3  <= led.mode;
		end
	end

	assign red_o   = div255(red_s3);
	assign green_o = div255(green_s3);
	assign blue_o  = div255(blue_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {6'd0, mode_s3, level_s3, blue_o, green_o, red_o};
		end
	end

	assign m_tvalid = valid_q;

endmodule

### sv/rlmc_chk.sv
module rlmc_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [rlmc_pkg::M_TDATA_W-1:0] m_tdata
);
	import rlmc_pkg::*;

	// a stalled result beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] == MODE_ON |-> m_tdata[31:24] == LEVEL_MAX)
		else $error("on mode without full level");

	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] == MODE_OFF |-> m_tdata[31:24] == LEVEL_MIN)
		else $error("off mode with nonzero level");

	a_dark_colour: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31:24] == LEVEL_MIN |-> m_tdata[23:0] == 24'd0)
		else $error("colour lit at zero level");

endmodule

bind rgb_led_mode_controller rlmc_chk u_rlmc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### test/tb_rgb_led_mode_controller.sv
module tb_rgb_led_mode_controller;
	import rlmc_pkg::*;

	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int HALF_PERIOD = 6;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] level;
		mode_t      mode;
	} led_view_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [S_TUSER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	// mirror of the LED state and its registers
	mode_t             led_mode;
	logic [7:0]        led_level;
	logic              led_fading_down;
	logic [TICK_W-1:0] led_elapsed;
	logic [7:0]        led_red, led_green, led_blue;
	logic [15:0]       blink_ms, pulse_ms;
	logic [7:0]        fade_amt;

	led_view_t pending_leds[$];
	int  fail_count = 0;
	int  beats_sent = 0;
	int  results_seen = 0;
	int  cfg_writes = 0;
	int  hold_request = 0;
	int  hold_left = 0;
	int  rx_gap = 0;
	bit  tx_idle_on, rx_idle_on;

	always #HALF_PERIOD clk = ~clk;

	rgb_led_mode_controller u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	function automatic logic [7:0] dim(input logic [7:0] c);
		int unsigned p;
		p = int'(c) * int'(led_level);
		return 8'(p / 255);
	endfunction

	function automatic void reset_led_mirror();
		blink_ms        = BLINK_RST;
		pulse_ms        = PULSE_RST;
		fade_amt        = FADE_RST;
		led_mode        = MODE_ON;
		led_level       = LEVEL_MAX;
		led_fading_down = 1'b0;
		led_elapsed     = TICK_SAT;
		led_red         = 8'd0;
		led_green       = 8'd255;
		led_blue        = 8'd0;
	endfunction

	function automatic void step_led_state(input logic [1:0] req, input logic [1:0] nm,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int        lv;
		mode_t     m;
		led_view_t v;
		case (req)
		REQ_TICK: begin
			if (led_elapsed != TICK_SAT)
				led_elapsed++;
			case (led_mode)
			MODE_OFF: led_level = LEVEL_MIN;
			MODE_BLINK: begin
				if (led_elapsed > blink_ms) begin
					led_level   = (led_level == LEVEL_MIN) ? LEVEL_MAX : LEVEL_MIN;
					led_elapsed = '0;
				end
			end
			MODE_PULSE: begin
				if (led_elapsed > pulse_ms) begin
					lv = led_fading_down ? int'(led_level) - int'(fade_amt)
						: int'(led_level) + int'(fade_amt);
					if (lv < 0)
						lv = 0;
					if (lv > 255)
						lv = 255;
					led_level = 8'(lv);
					// reverse at either end, even when the step is zero
					if (led_level == LEVEL_MIN || led_level == LEVEL_MAX)
						led_fading_down = ~led_fading_down;
					led_elapsed = '0;
				end
			end
			default: led_level = LEVEL_MAX;
			endcase
		end
		REQ_MODE: begin
			m = mode_t'(nm);
			if (m != led_mode) begin
				led_mode = m;
				case (m)
				MODE_ON:  led_level = LEVEL_MAX;
				MODE_OFF: led_level = LEVEL_MIN;
				MODE_PULSE: begin
					led_level       = LEVEL_MIN;
					led_fading_down = 1'b0;
				end
				default: ;
				endcase
			end
		end
		REQ_COLOUR: begin
			led_red   = r;
			led_green = g;
			led_blue  = b;
		end
		default: ;
		endcase
		v.red   = dim(led_red);
		v.green = dim(led_green);
		v.blue  = dim(led_blue);
		v.level = led_level;
		v.mode  = led_mode;
		pending_leds.push_back(v);
	endfunction

	function automatic void check_led(input logic [M_TDATA_W-1:0] d);
		led_view_t e;
		if (pending_leds.size() == 0) begin
			$error("result beat with nothing expected: %h", d);
			fail_count++;
			return;
		end
		e = pending_leds.pop_front();
		results_seen++;
		if (d[7:0] !== e.red) begin
			$error("red_out: expected %0d, got %0d", e.red, d[7:0]);
			fail_count++;
		end
		if (d[15:8] !== e.green) begin
			$error("green_out: expected %0d, got %0d", e.green, d[15:8]);
			fail_count++;
		end
		if (d[23:16] !== e.blue) begin
			$error("blue_out: expected %0d, got %0d", e.blue, d[23:16]);
			fail_count++;
		end
		if (d[31:24] !== e.level) begin
			$error("level_out: expected %0d, got %0d", e.level, d[31:24]);
			fail_count++;
		end
		if (d[33:32] !== e.mode) begin
			$error("mode_out: expected %0d, got %0d", e.mode, d[33:32]);
			fail_count++;
		end
	endfunction

	// result side: check each beat, then decide the next tready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_led(m_tdata);
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (rx_gap != 0) begin
			m_tready <= 1'b0;
			rx_gap--;
		end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			rx_gap = $urandom_range(0, 12);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_beat(input logic [1:0] req, input logic [1:0] nm,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {6'b0, b, g, r, nm};
		do @(posedge clk); while (!s_tready);
		step_led_state(req, nm, r, g, b);
		beats_sent++;
	endtask

	task automatic send_random_beat();
		int unsigned pick;
		logic [1:0]  req;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			req = REQ_TICK;
		else if (pick < 78)
			req = REQ_MODE;
		else if (pick < 95)
			req = REQ_COLOUR;
		else
			req = REQ_SPARE;
		send_beat(req, 2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_leds.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		CFG_BLINK: blink_ms = data;
		CFG_PULSE: pulse_ms = data;
		CFG_FADE:  fade_amt = data[7:0];
		default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic write_settings(input logic [15:0] blink, input logic [15:0] pulse,
		input logic [7:0] fade);
		write_reg(CFG_BLINK, blink);
		write_reg(CFG_PULSE, pulse);
		write_reg(CFG_FADE, {8'd0, fade});
	endtask

	// reset state, every request kind, colour extremes and mode entry presets
	task automatic test_requests_after_reset();
		send_beat(REQ_TICK, 2'b00, 8'h00, 8'h00, 8'h00);
		send_beat(REQ_SPARE, 2'b11, 8'hFF, 8'hFF, 8'hFF);
		send_beat(REQ_MODE, MODE_ON, 8'h00, 8'h00, 8'h00);
		send_beat(REQ_MODE, MODE_BLINK, 8'h00, 8'h00, 8'h00);
		// counter is still saturated from reset, so the first tick toggles
		send_beat(REQ_TICK, 2'b00, 8'h00, 8'h00, 8'h00);
		send_beat(REQ_TICK, 2'b00, 8'h00, 8'h00, 8'h00);
		send_beat(REQ_COLOUR, 2'b11, 8'hFF, 8'hFF, 8'hFF);
		send_beat(REQ_MODE, MODE_ON, 8'h00, 8'h00, 8'h00);
		send_beat(REQ_COLOUR, 2'b00, 8'h00, 8'h00, 8'h00);
		send_beat(REQ_COLOUR, 2'b10, 8'hFF, 8'h00, 8'h80);
		send_beat(REQ_TICK, 2'b01, 8'h55, 8'hAA, 8'h55);
		send_beat(REQ_MODE, MODE_OFF, 8'h00, 8'h00, 8'h00);
		send_beat(REQ_TICK, 2'b00, 8'h00, 8'h00, 8'h00);
		send_beat(REQ_MODE, MODE_OFF, 8'h00, 8'h00, 8'h00);
		send_beat(REQ_MODE, MODE_PULSE, 8'h00, 8'h00, 8'h00);
		repeat (4) send_beat(REQ_TICK, 2'b00, 8'h00, 8'h00, 8'h00);
		send_beat(REQ_COLOUR, 2'b00, 8'h7F, 8'hFE, 8'h01);
		send_beat(REQ_SPARE, 2'b00, 8'h00, 8'h00, 8'h00);
		send_beat(REQ_MODE, MODE_BLINK, 8'h00, 8'h00, 8'h00);
	endtask

	// period and step extremes, uneven step with clamping, zero step
	task automatic test_register_extremes();
		logic [15:0] blinks[5] = '{16'd0, 16'd0, 16'hFFFF, 16'd1, 16'd0};
		logic [15:0] pulses[5] = '{16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd1};
		logic [7:0]  fades[5]  = '{8'd255, 8'd0, 8'd1, 8'd100, 8'd1};
		for (int s = 0; s < 5; s++) begin
			write_settings(blinks[s], pulses[s], fades[s]);
			send_beat(REQ_MODE, MODE_ON, 8'h00, 8'h00, 8'h00);
			send_beat(REQ_MODE, MODE_PULSE, 8'h00, 8'h00, 8'h00);
			repeat (7) send_beat(REQ_TICK, 2'b00, 8'h00, 8'h00, 8'h00);
			send_beat(REQ_MODE, MODE_BLINK, 8'h00, 8'h00, 8'h00);
			repeat (3) send_beat(REQ_TICK, 2'b00, 8'h00, 8'h00, 8'h00);
		end
	endtask

	task automatic test_output_backpressure();
		tx_idle_on   = 1'b0;
		rx_idle_on   = 1'b0;
		hold_request = 300;
		repeat (60) send_random_beat();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_pause_until_empty();
		repeat (20) send_random_beat();
		wait_drained();
		repeat (20) send_random_beat();
	endtask

	task automatic test_random_settings(input int phases, input int beats_per_phase);
		logic [15:0] blink, pulse;
		logic [7:0]  fade;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(0, 9))
			0:       blink = 16'hFFFF;
			1:       blink = 16'($urandom);
			default: blink = 16'($urandom_range(0, 40));
			endcase
			case ($urandom_range(0, 9))
			0:       pulse = 16'hFFFF;
			1:       pulse = 16'($urandom);
			default: pulse = 16'($urandom_range(0, 8));
			endcase
			fade = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(1, 255));
			write_settings(blink, pulse, fade);
			repeat (beats_per_phase) send_random_beat();
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		m_tready   = 1'b0;
		cfg_we     = 1'b0;
		cfg_idx    = '0;
		cfg_data   = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		reset_led_mirror();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_requests_after_reset();
		test_register_extremes();
		test_output_backpressure();
		test_pause_until_empty();
		test_random_settings(4, 180);
		wait_drained();
		// no idling for the closing stretch
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		test_random_settings(1, 200);
		wait_drained();
		repeat (10) @(posedge clk);

		$display("checked %0d LED results from %0d request beats, %0d register writes",
			results_seen, beats_sent, cfg_writes);
		$display("all modes, colour extremes, clamped and zero fade steps, long output stall");
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#(2 * HALF_PERIOD * 600000);
		$display("status: fail");
		$finish;
	end

endmodule
